/* rtl/segment_x_clip_defines.svh */
// segment_x_clip_defines.svh: assertion macros for the x clipper checker.
// Needs a clk and an active-low arst_n in the scope where they are used.
`ifndef SEGMENT_X_CLIP_DEFINES_SVH
`define SEGMENT_X_CLIP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SXC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SXC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sxc_pkg.sv */
// sxc_pkg: widths, operand struct and x clamp helper for the segment x clipper.
// Used by sxc_interp and segment_x_clip; depends on nothing.
package sxc_pkg;

	localparam int COORD_W = 16;            // signed coordinate width
	localparam int X_W     = 15;            // clipped x / screen width
	localparam int DIFF_W  = COORD_W + 1;   // difference of two coordinates
	localparam int MAG_W   = COORD_W;       // magnitude of any operand
	localparam int PROD_W  = 2 * MAG_W;     // |dy| * |num|
	localparam int QUO_W   = COORD_W + 1;   // quotient bits kept before saturation

	localparam logic [X_W-1:0] WIDTH_RESET = X_W'(1280);

	// One interpolation request: result = base + trunc(dy * num / den)
	typedef struct packed {
		logic                     act;   // move this endpoint (den is nonzero)
		logic signed [COORD_W-1:0] base;
		logic signed [COORD_W-1:0] keep;  // y when no move is made
		logic signed [DIFF_W-1:0]  dy;
		logic signed [DIFF_W-1:0]  num;
		logic signed [DIFF_W-1:0]  den;
	} interp_op_t;

	// Clamp a signed x into 0..w
	function automatic logic [X_W-1:0] clamp_x(input logic signed [COORD_W-1:0] x,
		input logic [X_W-1:0] w);
		logic [X_W-1:0] r;
		if (x[COORD_W-1]) begin
			r = '0;
		end else if (x[X_W-1:0] > w) begin
			r = w;
		end else begin
			r = x[X_W-1:0];
		end
		return r;
	endfunction

	// x lies within 0..w
	function automatic logic x_inside(input logic signed [COORD_W-1:0] x,
		input logic [X_W-1:0] w);
		return !x[COORD_W-1] && (x[X_W-1:0] <= w);
	endfunction

endpackage

/* rtl/sxc_interp.sv */
// sxc_interp: pipelined y interpolation, base + trunc(dy*num/den), saturated to 16 bits.
// Restoring divider, one quotient bit per stage; depends on sxc_pkg.
module sxc_interp #(
	parameter int SB_W = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  sxc_pkg::interp_op_t               in_op,
	input  logic [SB_W-1:0]                   in_sb,
	output logic                              out_valid,
	output logic signed [sxc_pkg::COORD_W-1:0] out_y,
	output logic [SB_W-1:0]                   out_sb
);

	localparam int CW    = sxc_pkg::COORD_W;
	localparam int MW    = sxc_pkg::MAG_W;
	localparam int PW    = sxc_pkg::PROD_W;
	localparam int QW    = sxc_pkg::QUO_W;
	localparam int DEPTH = QW + 4;   // magnitude, multiply, setup, QW steps, saturate

	typedef struct packed {
		logic                 neg;
		logic                 act;
		logic signed [CW-1:0] base;
		logic signed [CW-1:0] keep;
		logic [MW-1:0]        am;
		logic [MW-1:0]        bm;
		logic [MW-1:0]        dm;
	} mag_st_t;

	typedef struct packed {
		logic                 neg;
		logic                 act;
		logic signed [CW-1:0] base;
		logic signed [CW-1:0] keep;
		logic [PW-1:0]        prod;
		logic [MW-1:0]        dm;
	} mul_st_t;

	typedef struct packed {
		logic                 neg;
		logic                 act;
		logic                 ovf;
		logic signed [CW-1:0] base;
		logic signed [CW-1:0] keep;
		logic [MW-1:0]        den;
		logic [MW-1:0]        rem;
		logic [QW-1:0]        dvd;
		logic [QW-1:0]        quo;
	} div_st_t;

	function automatic logic [MW-1:0] mag(input logic signed [MW:0] v);
		logic [MW:0] t;
		t = v[MW] ? (~v + 1'b1) : v;
		return t[MW-1:0];
	endfunction

	// one restoring step: shift in a dividend bit, subtract when it fits
	function automatic div_st_t div_step(input div_st_t d);
		logic [MW:0] r;
		logic [MW:0] diff;
		logic        qb;
		div_st_t     n;
		n    = d;
		r    = {d.rem, d.dvd[QW-1]};
		diff = r - {1'b0, d.den};
		qb   = (r >= {1'b0, d.den});
		n.rem = qb ? diff[MW-1:0] : r[MW-1:0];
		n.dvd = {d.dvd[QW-2:0], 1'b0};
		n.quo = {d.quo[QW-2:0], qb};
		return n;
	endfunction

	logic [DEPTH-1:0] vld_s;
	logic [SB_W-1:0]  sb_s [DEPTH];
	mag_st_t          mag_s1;
	mul_st_t          mul_s2;
	div_st_t          div_s [QW+1];
	logic signed [CW-1:0] y_sf;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DEPTH-2:0], in_valid};
		end
	end

	// sideband shift line
	always_ff @(posedge clk) begin
		if (en) begin
			sb_s[0] <= in_sb;
			for (int i = 1; i < DEPTH; i++) begin
				sb_s[i] <= sb_s[i-1];
			end
		end
	end

	// stage 1: operand magnitudes and result sign
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1.neg  <= in_op.dy[MW] ^ in_op.num[MW] ^ in_op.den[MW];
			mag_s1.act  <= in_op.act;
			mag_s1.base <= in_op.base;
			mag_s1.keep <= in_op.keep;
			mag_s1.am   <= mag(in_op.dy);
			mag_s1.bm   <= mag(in_op.num);
			mag_s1.dm   <= mag(in_op.den);
		end
	end

	// stage 2: product of magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			mul_s2.neg  <= mag_s1.neg;
			mul_s2.act  <= mag_s1.act;
			mul_s2.base <= mag_s1.base;
			mul_s2.keep <= mag_s1.keep;
			mul_s2.prod <= mag_s1.am * mag_s1.bm;
			mul_s2.dm   <= mag_s1.dm;
		end
	end

	// stage 3: divider setup; a quotient of 2^QW or more saturates anyway
	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].neg  <= mul_s2.neg;
			div_s[0].act  <= mul_s2.act;
			div_s[0].ovf  <= {1'b0, mul_s2.prod[PW-1:QW]} >= mul_s2.dm;
			div_s[0].base <= mul_s2.base;
			div_s[0].keep <= mul_s2.keep;
			div_s[0].den  <= mul_s2.dm;
			div_s[0].rem  <= {1'b0, mul_s2.prod[PW-1:QW]};
			div_s[0].dvd  <= mul_s2.prod[QW-1:0];
			div_s[0].quo  <= '0;
		end
	end

	// divider stages, MSB first
	for (genvar k = 0; k < QW; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k+1] <= div_step(div_s[k]);
			end
		end
	end

	// final stage: apply sign, add base, saturate; pass keep when act is low
	logic signed [CW+2:0] q_ext;
	logic signed [CW+2:0] sum;
	logic signed [CW-1:0] y_next;
	localparam logic signed [CW-1:0] Y_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] Y_MIN = {1'b1, {(CW-1){1'b0}}};

	always_comb begin
		q_ext = div_s[QW].neg ? -$signed({2'b00, div_s[QW].quo})
			: $signed({2'b00, div_s[QW].quo});
		sum   = $signed({{3{div_s[QW].base[CW-1]}}, div_s[QW].base}) + q_ext;
		if (!div_s[QW].act) begin
			y_next = div_s[QW].keep;
		end else if (div_s[QW].ovf) begin
			y_next = div_s[QW].neg ? Y_MIN : Y_MAX;
		end else if (sum > $signed({3'b000, Y_MAX})) begin
			y_next = Y_MAX;
		end else if (sum < $signed({3'b111, Y_MIN})) begin
			y_next = Y_MIN;
		end else begin
			y_next = sum[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_sf <= y_next;
		end
	end

	assign out_valid = vld_s[DEPTH-1];
	assign out_sb    = sb_s[DEPTH-1];
	assign out_y     = y_sf;

endmodule

/* rtl/segment_x_clip.sv */
// segment_x_clip: top level of the segment x clipper.
// Depends on sxc_pkg and sxc_interp.
//
// Usage:
//   Input channel in_valid/in_ready carries one segment request (in_x1, in_y1,
//   in_x2, in_y2, signed 16 bit). Output channel out_valid/out_ready carries the
//   clipped segment (out_x1/out_x2 in 0..screen_width, out_y1/out_y2 signed).
//   cfg_we/cfg_wdata write screen_width; write it only while the block is idle.
// Pipeline: acceptance loads the input register, then two 21-stage interpolation
//   units in series: endpoint 2 first, endpoint 1 after; when endpoint 1 crosses
//   the right edge and endpoint 2 the left edge, endpoint 1 goes through the first
//   unit instead.
// Throughput: one request per cycle while the output is not stalled. The depth
//   is set by the restoring dividers, one quotient bit per stage, 17 per unit.
// Reset: arst_n clears all valid bits and loads screen_width with 1280.
// Stall: when out_valid is high and out_ready low, the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated. in_ready = !out_valid | out_ready.
module segment_x_clip (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sxc_pkg::X_W-1:0]           cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [sxc_pkg::COORD_W-1:0] in_x1,
	input  logic signed [sxc_pkg::COORD_W-1:0] in_y1,
	input  logic signed [sxc_pkg::COORD_W-1:0] in_x2,
	input  logic signed [sxc_pkg::COORD_W-1:0] in_y2,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sxc_pkg::X_W-1:0]           out_x1,
	output logic signed [sxc_pkg::COORD_W-1:0] out_y1,
	output logic [sxc_pkg::X_W-1:0]           out_x2,
	output logic signed [sxc_pkg::COORD_W-1:0] out_y2
);

	localparam int CW    = sxc_pkg::COORD_W;
	localparam int XW    = sxc_pkg::X_W;
	localparam int DW    = sxc_pkg::DIFF_W;
	localparam int SB1_W = 4 * CW + XW + 2;
	localparam int SB2_W = 2 * XW + CW + 1;

	logic [XW-1:0] width_q;
	logic          en;

	// screen width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= sxc_pkg::WIDTH_RESET;
		end else if (cfg_we) begin
			width_q <= cfg_wdata;
		end
	end

	// global advance: the output register is free or being drained
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// input register
	logic                 vld_s1;
	logic signed [CW-1:0] x1_s1, y1_s1, x2_s1, y2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= in_x1;
			y1_s1 <= in_y1;
			x2_s1 <= in_x2;
			y2_s1 <= in_y2;
		end
	end

	// classify and build the first move: endpoint 2, or endpoint 1 at the right
	// edge when endpoint 1 lies right of the window and endpoint 2 left of it
	logic signed [DW-1:0] d1;
	logic                 small_dy;
	logic                 full1;
	logic                 swap1;
	logic [XW-1:0]        x2c1;
	logic [XW-1:0]        xe1;
	sxc_pkg::interp_op_t  op1;
	logic [SB1_W-1:0]     sb1_in;

	always_comb begin
		d1       = $signed({y2_s1[CW-1], y2_s1}) - $signed({y1_s1[CW-1], y1_s1});
		small_dy = (d1 >= -DW'(2)) && (d1 <= DW'(2));
		full1    = !(sxc_pkg::x_inside(x1_s1, width_q) && sxc_pkg::x_inside(x2_s1, width_q))
			&& !small_dy;
		swap1    = full1 && !x1_s1[CW-1] && !sxc_pkg::x_inside(x1_s1, width_q)
			&& x2_s1[CW-1];
		x2c1     = sxc_pkg::clamp_x(x2_s1, width_q);
		xe1      = swap1 ? width_q : x2c1;
		op1.act  = full1 && (swap1
			|| (!sxc_pkg::x_inside(x2_s1, width_q) && (x2_s1 != x1_s1)));
		op1.base = y2_s1;
		op1.keep = y2_s1;
		op1.dy   = d1;
		op1.num  = $signed({2'b00, xe1}) - $signed({x2_s1[CW-1], x2_s1});
		op1.den  = $signed({x2_s1[CW-1], x2_s1}) - $signed({x1_s1[CW-1], x1_s1});
		sb1_in   = {x1_s1, y1_s1, x2_s1, y2_s1, x2c1, full1, swap1};
	end

	logic                 vld_m;
	logic signed [CW-1:0] y2p;
	logic [SB1_W-1:0]     sb1_out;

	sxc_interp #(.SB_W(SB1_W)) u_interp_e2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s1),
		.in_op    (op1),
		.in_sb    (sb1_in),
		.out_valid(vld_m),
		.out_y    (y2p),
		.out_sb   (sb1_out)
	);

	// second move, from the endpoint updated by the first
	logic signed [CW-1:0] x1_m, y1_m, x2_m, y2_m;
	logic [XW-1:0]        x2c_m, x1c_m;
	logic                 full_m;
	logic                 swap_m;
	sxc_pkg::interp_op_t  op2;
	logic [SB2_W-1:0]     sb2_in;

	always_comb begin
		{x1_m, y1_m, x2_m, y2_m, x2c_m, full_m, swap_m} = sb1_out;
		x1c_m = sxc_pkg::clamp_x(x1_m, width_q);
		if (swap_m) begin
			// endpoint 2 to the left edge, endpoint 1 already at the right edge
			op2.act  = 1'b1;
			op2.base = y2_m;
			op2.keep = y2_m;
			op2.dy   = $signed({y2_m[CW-1], y2_m}) - $signed({y2p[CW-1], y2p});
			op2.num  = $signed({x2_m[CW-1], x2_m});
			op2.den  = $signed({2'b00, x1c_m}) - $signed({x2_m[CW-1], x2_m});
		end else begin
			op2.act  = full_m && !sxc_pkg::x_inside(x1_m, width_q)
				&& ($signed({1'b0, x2c_m}) != x1_m);
			op2.base = y2p;
			op2.keep = y1_m;
			op2.dy   = $signed({y2p[CW-1], y2p}) - $signed({y1_m[CW-1], y1_m});
			op2.num  = $signed({2'b00, x1c_m}) - $signed({2'b00, x2c_m});
			op2.den  = $signed({2'b00, x2c_m}) - $signed({x1_m[CW-1], x1_m});
		end
		sb2_in = {x1c_m, x2c_m, y2p, swap_m};
	end

	logic [SB2_W-1:0]     sb2_out;
	logic signed [CW-1:0] y_e1;
	logic signed [CW-1:0] y_pass;
	logic                 swap_o;

	sxc_interp #(.SB_W(SB2_W)) u_interp_e1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_m),
		.in_op    (op2),
		.in_sb    (sb2_in),
		.out_valid(out_valid),
		.out_y    (y_e1),
		.out_sb   (sb2_out)
	);

	// put the two y values back on their endpoints
	assign {out_x1, out_x2, y_pass, swap_o} = sb2_out;
	assign out_y1 = swap_o ? y_pass : y_e1;
	assign out_y2 = swap_o ? y_e1 : y_pass;

endmodule

/* rtl/sxc_checker.sv */
// sxc_checker: port-level assertions for segment_x_clip, bound to the top level.
// Depends on segment_x_clip_defines.svh.
`include "segment_x_clip_defines.svh"

module sxc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [14:0] cfg_wdata,
	input logic        in_valid,
	input logic        in_ready,
	input logic [15:0] in_x1,
	input logic [15:0] in_y1,
	input logic [15:0] in_x2,
	input logic [15:0] in_y2,
	input logic        out_valid,
	input logic        out_ready,
	input logic [14:0] out_x1,
	input logic [15:0] out_y1,
	input logic [14:0] out_x2,
	input logic [15:0] out_y2
);

	// stalled result stays up
	`SXC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped under stall")

	// stalled result payload holds
	`SXC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
		$stable(out_x1) && $stable(out_y1) && $stable(out_x2) && $stable(out_y2),
		"result changed under stall")

	// input is refused only while a result waits
	`SXC_ASSERT_NOW(a_ready_rule, 1'b1, in_ready == (!out_valid || out_ready),
		"in_ready disagrees with output stall")

	// pipeline comes out of reset empty
	`SXC_ASSERT_NOW(a_reset_empty, $rose(arst_n), !out_valid, "result present after reset")

endmodule

bind segment_x_clip sxc_checker u_sxc_checker (.*);

/* verif/segment_x_clip_test.sv */
`timescale 1ns / 100ps
// segment_x_clip_test: self-checking bench for the segment x clipper.
// Depends on sxc_pkg and segment_x_clip; predicts each clipped segment in order.

class clip_scoreboard;
	typedef struct {
		logic [14:0] x1;
		logic signed [15:0] y1;
		logic [14:0] x2;
		logic signed [15:0] y2;
	} seg_t;

	seg_t pending[$];
	logic [14:0] width;
	int errors;

	function new();
		width = sxc_pkg::WIDTH_RESET;
		errors = 0;
	endfunction

	// base + trunc(dy * num / den), saturated to 16 bits
	function longint lerp_y(longint base, longint dy, longint num, longint den);
		longint q;
		bit neg;
		neg = (dy < 0) ^ (num < 0) ^ (den < 0);
		q = ((dy < 0 ? -dy : dy) * (num < 0 ? -num : num)) / (den < 0 ? -den : den);
		return sat16(neg ? base - q : base + q);
	endfunction

	function longint sat16(longint v);
		return v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
	endfunction

	function longint clampw(longint v, longint w);
		return v < 0 ? 0 : (v > w ? w : v);
	endfunction

	// Note an accepted request and queue its clipped segment
	function void note_request(logic signed [15:0] ix1, logic signed [15:0] iy1,
		logic signed [15:0] ix2, logic signed [15:0] iy2);
		longint w, x1, y1, x2, y2, d;
		seg_t s;
		w = width; x1 = ix1; y1 = iy1; x2 = ix2; y2 = iy2;
		if (!(x1 >= 0 && x1 <= w && x2 >= 0 && x2 <= w)) begin
			d = y2 - y1;
			if (d >= -2 && d <= 2) begin
				x1 = clampw(x1, w);
				x2 = clampw(x2, w);
			end else begin
				if (x2 > w) begin
					if (x2 != x1) y2 = lerp_y(y2, y2 - y1, w - x2, x2 - x1);
					x2 = w;
				end
				if (x1 > w) begin
					if (x2 != x1) y1 = lerp_y(y2, y2 - y1, w - x2, x2 - x1);
					x1 = w;
				end
				if (x2 < 0) begin
					if (x1 != x2) y2 = lerp_y(y2, y2 - y1, x2, x1 - x2);
					x2 = 0;
				end
				if (x1 < 0) begin
					if (x1 != x2) y1 = lerp_y(y2, y2 - y1, x2, x1 - x2);
					x1 = 0;
				end
			end
		end
		s.x1 = x1[14:0]; s.y1 = y1[15:0]; s.x2 = x2[14:0]; s.y2 = y2[15:0];
		pending.push_back(s);
	endfunction

	// Compare one returned segment with the oldest prediction
	function void check_segment(logic [14:0] ax1, logic signed [15:0] ay1,
		logic [14:0] ax2, logic signed [15:0] ay2);
		seg_t s;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected segment %0d %0d %0d %0d", ax1, ay1, ax2, ay2);
			return;
		end
		s = pending.pop_front();
		if (s.x1 !== ax1 || s.y1 !== ay1 || s.x2 !== ax2 || s.y2 !== ay2) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
					s.x1, s.y1, s.x2, s.y2, ax1, ay1, ax2, ay2);
		end
	endfunction
endclass

module segment_x_clip_test;
	localparam int LATENCY = 42;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [14:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] in_x1 = '0, in_y1 = '0, in_x2 = '0, in_y2 = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [14:0] out_x1, out_x2;
	logic signed [15:0] out_y1, out_y2;

	clip_scoreboard board = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;
	longint cycles = 0;

	segment_x_clip u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_x1(in_x1), .in_y1(in_y1), .in_x2(in_x2), .in_y2(in_y2),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x1(out_x1), .out_y1(out_y1), .out_x2(out_x2), .out_y2(out_y2)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: random stalls plus a long hold-off on request
	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.check_segment(out_x1, out_y1, out_x2, out_y2);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Send one segment request; wait until it is accepted.
	// in_valid stays high after acceptance until an idle cycle or a stop.
	task automatic send_segment(logic signed [15:0] x1, logic signed [15:0] y1,
		logic signed [15:0] x2, logic signed [15:0] y2);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_x1 <= x1; in_y1 <= y1; in_x2 <= x2; in_y2 <= y2;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_request(x1, y1, x2, y2);
	endtask

	// Wait for all predictions to drain, then write the width
	task automatic set_width(logic [14:0] w);
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.width = w;
	endtask

	function automatic logic signed [15:0] rand_x(logic [14:0] w);
		case ($urandom_range(5))
			0: return 16'($urandom);
			1: return 16'($urandom_range(w));
			2: return -$signed({1'b0, 15'($urandom_range(300))});
			3: return 16'(w) + 16'($urandom_range(300));
			4: return $urandom_range(1) ? 16'(w) : 16'sd0;
			default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
		endcase
	endfunction

	task automatic random_batch(int n);
		logic signed [15:0] y1;
		for (int i = 0; i < n; i++) begin
			y1 = 16'($urandom);
			send_segment(rand_x(board.width), y1, rand_x(board.width),
				$urandom_range(3) == 0 ? y1 + $signed(16'($urandom_range(4))) - 16'sd2
					: 16'($urandom));
		end
	endtask

	initial begin
		logic [14:0] widths[5];
		widths = '{15'd1, 15'd32767, 15'd640, 15'd0, 15'($urandom_range(1, 32767))};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset width, edges, extremes, small dy, zero denominator
		send_segment(16'sd10, 16'sd5, 16'sd1000, 16'sd9);
		send_segment(16'sd0, 16'sd0, 16'sd1280, 16'sd100);
		send_segment(-16'sd100, 16'sd0, 16'sd2000, 16'sd1);
		send_segment(-16'sd100, 16'sd0, 16'sd2000, 16'sd2);
		send_segment(-16'sd100, 16'sd0, 16'sd2000, -16'sd2);
		send_segment(-16'sd100, 16'sd0, 16'sd2000, 16'sd3000);
		send_segment(16'sd2000, 16'sd0, -16'sd100, -16'sd3000);
		send_segment(16'sd2000, 16'sd0, 16'sd2000, 16'sd500);
		send_segment(-16'sd5, 16'sd0, -16'sd5, 16'sd500);
		send_segment(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
		send_segment(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
		send_segment(16'sd1300, 16'sd10, 16'sd1500, 16'sd900);
		send_segment(-16'sd300, -16'sd10, -16'sd1, 16'sh7fff);
		send_segment(16'sd1281, 16'sh8000, -16'sd1, 16'sh7fff);
		send_segment(16'sd640, 16'sd0, 16'sd1281, 16'shffff);

		// Phases: widths with idle and stall patterns
		for (int p = 0; p < 5; p++) begin
			set_width(widths[p]);
			send_idle_pct = 0; recv_stall_pct = 0; random_batch(120);
			send_idle_pct = 77; recv_stall_pct = 0; random_batch(70);
			send_idle_pct = 0; recv_stall_pct = 77; random_batch(100);
			send_idle_pct = 24; recv_stall_pct = 24; random_batch(90);
			if (p == 2) begin
				send_idle_pct = 0;
				hold_off = 200;
				random_batch(20);
			end
		end
		set_width(15'd1280);
		recv_stall_pct = 10;
		random_batch(100);
		in_valid <= 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (board.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
